// ===== rtl/core/tlsrc_pkg.sv =====
// ----------------------------------------------------------------------------
// tlsrc_pkg
// Shared codes and control/status bundles for the two-list store.
// ----------------------------------------------------------------------------
package tlsrc_pkg;

    // request kinds
    localparam logic [2:0] KIND_APPEND  = 3'd0;
    localparam logic [2:0] KIND_REVERSE = 3'd1;
    localparam logic [2:0] KIND_SORT    = 3'd2;
    localparam logic [2:0] KIND_CONCAT  = 3'd3;
    localparam logic [2:0] KIND_DISPLAY = 3'd4;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // element store write data source
    typedef enum logic [1:0] {
        WD_VALUE = 2'd0,
        WD_RDATA = 2'd1,
        WD_AREG  = 2'd2
    } wd_sel_t;

    typedef struct packed {
        logic       cap;          // capture request payload
        logic       rd_en;
        logic       wr_en;
        wd_sel_t    wd_sel;
        logic       a_load;       // hold register takes read data
        logic       len_inc;
        logic       len_inc_sel;  // 0 list one, 1 list two
        logic       len_cat;      // list one length += list two length
        logic       out_load;
        logic       out_from_mem; // 1 element result, 0 status result
        logic       out_last;
        logic [1:0] out_status;
        logic [4:0] out_count;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
        logic a_gt_rd;
    } dp_stat_t;

endpackage

// ===== rtl/core/tlsrc_in_if.sv =====
// ----------------------------------------------------------------------------
// tlsrc_in_if
// Request channel: valid/ready handshake with the operation payload.
// ----------------------------------------------------------------------------
interface tlsrc_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic               list_select;
    logic signed [31:0] value;

    modport source (output valid, output kind, output list_select, output value,
                    input ready);
    modport sink   (input valid, input kind, input list_select, input value,
                    output ready);
endinterface

// ===== rtl/core/tlsrc_out_if.sv =====
// ----------------------------------------------------------------------------
// tlsrc_out_if
// Result channel: valid/ready handshake with one result per beat.
// ----------------------------------------------------------------------------
interface tlsrc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value_res;
    logic               last;
    logic [1:0]         status;
    logic [4:0]         count;

    modport source (output valid, output value_res, output last, output status,
                    output count, input ready);
    modport sink   (input valid, input value_res, input last, input status,
                    input count, output ready);
endinterface

// ===== rtl/core/tlsrc_datapath.sv =====
// ----------------------------------------------------------------------------
// tlsrc_datapath
// Element store, read register, hold register, list lengths, result register.
// ----------------------------------------------------------------------------
module tlsrc_datapath #(
    parameter int LIST_DEPTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tlsrc_pkg::dp_cmd_t                cmd,
    input  logic [$clog2(2*LIST_DEPTH)-1:0]   rd_addr,
    input  logic [$clog2(2*LIST_DEPTH)-1:0]   wr_addr,
    input  logic signed [31:0]                in_value,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic signed [31:0]                out_value,
    output logic                              out_last,
    output logic [1:0]                        out_status,
    output logic [4:0]                        out_count,
    output tlsrc_pkg::dp_stat_t               stat,
    output logic [$clog2(LIST_DEPTH+1)-1:0]   len1,
    output logic [$clog2(LIST_DEPTH+1)-1:0]   len2
);

    localparam int LW = $clog2(LIST_DEPTH+1);
    localparam int MD = 2*LIST_DEPTH;

    logic signed [31:0] elem_mem [MD];
    logic signed [31:0] rdata_reg;
    logic signed [31:0] a_reg;
    logic signed [31:0] value_reg;
    logic signed [31:0] wr_data;
    logic [LW-1:0]      len1_reg, len1_next;
    logic [LW-1:0]      len2_reg, len2_next;
    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] out_value_reg;
    logic               out_last_reg;
    logic [1:0]         out_status_reg;
    logic [4:0]         out_count_reg;

    always_comb
    begin
        case (cmd.wd_sel)
            tlsrc_pkg::WD_VALUE: wr_data = value_reg;
            tlsrc_pkg::WD_RDATA: wr_data = rdata_reg;
            tlsrc_pkg::WD_AREG:  wr_data = a_reg;
            default:             wr_data = rdata_reg;
        endcase
    end

    // single write port, single registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            elem_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= elem_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            value_reg <= in_value;
        end
        if (cmd.a_load)
        begin
            a_reg <= rdata_reg;
        end
        if (cmd.out_load)
        begin
            out_value_reg  <= cmd.out_from_mem ? rdata_reg : 32'sd0;
            out_last_reg   <= cmd.out_last;
            out_status_reg <= cmd.out_status;
            out_count_reg  <= cmd.out_count;
        end
    end

    always_comb
    begin
        len1_next = len1_reg;
        len2_next = len2_reg;
        if (cmd.len_inc)
        begin
            if (cmd.len_inc_sel)
            begin
                len2_next = len2_reg + 1'b1;
            end
            else
            begin
                len1_next = len1_reg + 1'b1;
            end
        end
        if (cmd.len_cat)
        begin
            len1_next = len1_reg + len2_reg;
        end
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len1_reg      <= '0;
            len2_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len1_reg      <= len1_next;
            len2_reg      <= len2_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign stat.out_free = !out_valid_reg || out_ready;
    assign stat.a_gt_rd  = a_reg > rdata_reg;

    assign out_valid  = out_valid_reg;
    assign out_value  = out_value_reg;
    assign out_last   = out_last_reg;
    assign out_status = out_status_reg;
    assign out_count  = out_count_reg;
    assign len1       = len1_reg;
    assign len2       = len2_reg;

endmodule

// ===== rtl/core/tlsrc_ctrl.sv =====
// ----------------------------------------------------------------------------
// tlsrc_ctrl
// Sequencer for append, reverse, exchange sort, concat and list display.
// ----------------------------------------------------------------------------
module tlsrc_ctrl #(
    parameter int LIST_DEPTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic [2:0]                        in_kind,
    input  logic                              in_sel,
    output logic                              in_ready,
    input  tlsrc_pkg::dp_stat_t               stat,
    input  logic [$clog2(LIST_DEPTH+1)-1:0]   len1,
    input  logic [$clog2(LIST_DEPTH+1)-1:0]   len2,
    output tlsrc_pkg::dp_cmd_t                cmd,
    output logic [$clog2(2*LIST_DEPTH)-1:0]   rd_addr,
    output logic [$clog2(2*LIST_DEPTH)-1:0]   wr_addr
);

    localparam int AW = $clog2(2*LIST_DEPTH);
    localparam int LW = $clog2(LIST_DEPTH+1);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISP     = 4'd1;
    localparam logic [3:0] S_REV_CHK  = 4'd2;
    localparam logic [3:0] S_REV_RJ   = 4'd3;
    localparam logic [3:0] S_REV_WI   = 4'd4;
    localparam logic [3:0] S_REV_WJ   = 4'd5;
    localparam logic [3:0] S_SORT_I   = 4'd6;
    localparam logic [3:0] S_SORT_A   = 4'd7;
    localparam logic [3:0] S_SORT_C   = 4'd8;
    localparam logic [3:0] S_SORT_W   = 4'd9;
    localparam logic [3:0] S_CAT      = 4'd10;
    localparam logic [3:0] S_CAT_W    = 4'd11;
    localparam logic [3:0] S_SHOW_CHK = 4'd12;
    localparam logic [3:0] S_SHOW_RD  = 4'd13;
    localparam logic [3:0] S_SHOW_OUT = 4'd14;
    localparam logic [3:0] S_STAT     = 4'd15;

    logic [3:0]    state_reg, state_next;
    logic [2:0]    kind_reg, kind_next;
    logic          sel_reg, sel_next;
    logic [LW-1:0] i_reg, i_next;
    logic [LW-1:0] j_reg, j_next;
    logic [1:0]    stat_code_reg, stat_code_next;
    logic [4:0]    stat_count_reg, stat_count_next;
    logic [LW-1:0] len_cur;
    logic [LW-1:0] i_inc;
    logic [LW-1:0] j_inc;
    logic [LW:0]   cat_sum;

    function automatic logic [AW-1:0] elem_addr(input logic s, input logic [LW-1:0] idx);
        return s ? AW'(LIST_DEPTH) + AW'(idx) : AW'(idx);
    endfunction

    assign len_cur = sel_reg ? len2 : len1;
    assign i_inc   = i_reg + 1'b1;
    assign j_inc   = j_reg + 1'b1;
    assign cat_sum = {1'b0, len1} + {1'b0, len2};

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        sel_next        = sel_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        stat_code_next  = stat_code_reg;
        stat_count_next = stat_count_reg;
        cmd             = '0;
        rd_addr         = '0;
        wr_addr         = '0;
        in_ready        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.cap    = 1'b1;
                    kind_next  = in_kind;
                    sel_next   = in_sel;
                    state_next = S_DISP;
                end
            end

            S_DISP:
            begin
                i_next = '0;
                unique case (kind_reg)
                    tlsrc_pkg::KIND_APPEND:
                    begin
                        if (len_cur >= LW'(LIST_DEPTH))
                        begin
                            stat_code_next  = tlsrc_pkg::ST_FULL;
                            stat_count_next = 5'(len_cur);
                        end
                        else
                        begin
                            cmd.wr_en       = 1'b1;
                            cmd.wd_sel      = tlsrc_pkg::WD_VALUE;
                            wr_addr         = elem_addr(sel_reg, len_cur);
                            cmd.len_inc     = 1'b1;
                            cmd.len_inc_sel = sel_reg;
                            stat_code_next  = tlsrc_pkg::ST_OK;
                            stat_count_next = 5'(len_cur + 1'b1);
                        end
                        state_next = S_STAT;
                    end
                    tlsrc_pkg::KIND_REVERSE:
                    begin
                        j_next = len_cur - 1'b1;
                        if (len_cur >= LW'(2))
                        begin
                            state_next = S_REV_CHK;
                        end
                        else
                        begin
                            state_next = S_SHOW_CHK;
                        end
                    end
                    tlsrc_pkg::KIND_SORT:
                    begin
                        state_next = S_SORT_I;
                    end
                    tlsrc_pkg::KIND_CONCAT:
                    begin
                        sel_next = 1'b0;
                        if (cat_sum > (LW+1)'(LIST_DEPTH))
                        begin
                            stat_code_next  = tlsrc_pkg::ST_FULL;
                            stat_count_next = 5'(len1);
                            state_next      = S_STAT;
                        end
                        else
                        begin
                            state_next = S_CAT;
                        end
                    end
                    tlsrc_pkg::KIND_DISPLAY:
                    begin
                        state_next = S_SHOW_CHK;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_REV_CHK:
            begin
                if (i_reg < j_reg)
                begin
                    cmd.rd_en  = 1'b1;
                    rd_addr    = elem_addr(sel_reg, i_reg);
                    state_next = S_REV_RJ;
                end
                else
                begin
                    state_next = S_SHOW_CHK;
                end
            end

            S_REV_RJ:
            begin
                cmd.a_load = 1'b1;
                cmd.rd_en  = 1'b1;
                rd_addr    = elem_addr(sel_reg, j_reg);
                state_next = S_REV_WI;
            end

            S_REV_WI:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wd_sel = tlsrc_pkg::WD_RDATA;
                wr_addr    = elem_addr(sel_reg, i_reg);
                state_next = S_REV_WJ;
            end

            S_REV_WJ:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wd_sel = tlsrc_pkg::WD_AREG;
                wr_addr    = elem_addr(sel_reg, j_reg);
                i_next     = i_inc;
                j_next     = j_reg - 1'b1;
                state_next = S_REV_CHK;
            end

            // outer pass: hold register carries the running minimum for slot i
            S_SORT_I:
            begin
                if (i_reg < len_cur)
                begin
                    cmd.rd_en  = 1'b1;
                    rd_addr    = elem_addr(sel_reg, i_reg);
                    j_next     = i_inc;
                    state_next = S_SORT_A;
                end
                else
                begin
                    state_next = S_SHOW_CHK;
                end
            end

            S_SORT_A:
            begin
                cmd.a_load = 1'b1;
                if (j_reg < len_cur)
                begin
                    cmd.rd_en  = 1'b1;
                    rd_addr    = elem_addr(sel_reg, j_reg);
                    state_next = S_SORT_C;
                end
                else
                begin
                    i_next     = i_inc;
                    state_next = S_SORT_I;
                end
            end

            // one compare per cycle; next read overlaps the swap write
            S_SORT_C:
            begin
                if (stat.a_gt_rd)
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wd_sel = tlsrc_pkg::WD_AREG;
                    wr_addr    = elem_addr(sel_reg, j_reg);
                    cmd.a_load = 1'b1;
                end
                j_next = j_inc;
                if (j_inc < len_cur)
                begin
                    cmd.rd_en = 1'b1;
                    rd_addr   = elem_addr(sel_reg, j_inc);
                end
                else
                begin
                    state_next = S_SORT_W;
                end
            end

            S_SORT_W:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wd_sel = tlsrc_pkg::WD_AREG;
                wr_addr    = elem_addr(sel_reg, i_reg);
                i_next     = i_inc;
                state_next = S_SORT_I;
            end

            S_CAT:
            begin
                if (i_reg < len2)
                begin
                    cmd.rd_en  = 1'b1;
                    rd_addr    = elem_addr(1'b1, i_reg);
                    state_next = S_CAT_W;
                end
                else
                begin
                    cmd.len_cat = 1'b1;
                    state_next  = S_SHOW_CHK;
                end
            end

            S_CAT_W:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wd_sel = tlsrc_pkg::WD_RDATA;
                wr_addr    = AW'(len1) + AW'(i_reg);
                i_next     = i_inc;
                state_next = S_CAT;
            end

            S_SHOW_CHK:
            begin
                i_next = '0;
                if (len_cur == '0)
                begin
                    stat_code_next  = tlsrc_pkg::ST_EMPTY;
                    stat_count_next = '0;
                    state_next      = S_STAT;
                end
                else
                begin
                    state_next = S_SHOW_RD;
                end
            end

            S_SHOW_RD:
            begin
                cmd.rd_en  = 1'b1;
                rd_addr    = elem_addr(sel_reg, i_reg);
                state_next = S_SHOW_OUT;
            end

            S_SHOW_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load     = 1'b1;
                    cmd.out_from_mem = 1'b1;
                    cmd.out_last     = (i_inc == len_cur);
                    cmd.out_status   = tlsrc_pkg::ST_OK;
                    cmd.out_count    = 5'(len_cur);
                    i_next           = i_inc;
                    state_next       = (i_inc == len_cur) ? S_IDLE : S_SHOW_RD;
                end
            end

            S_STAT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_last   = 1'b1;
                    cmd.out_status = stat_code_reg;
                    cmd.out_count  = stat_count_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            kind_reg       <= '0;
            sel_reg        <= 1'b0;
            i_reg          <= '0;
            j_reg          <= '0;
            stat_code_reg  <= '0;
            stat_count_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            kind_reg       <= kind_next;
            sel_reg        <= sel_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            stat_code_reg  <= stat_code_next;
            stat_count_reg <= stat_count_next;
        end
    end

endmodule

// ===== rtl/core/two_list_store_sort_reverse_concat_top.sv =====
// ----------------------------------------------------------------------------
// two_list_store_sort_reverse_concat_top
// Two bounded lists of signed 32-bit values with append, reverse, exchange
// sort, concat and display. One request is worked at a time. The element
// store has one write and one registered read port (one read, one write per
// cycle). Reverse reads both entries of a pair, then writes them back
// crossed; exchange sort does one compare per cycle, a swap write sharing
// its cycle with the next read; concat reads and writes each copied entry.
// Result back-pressure stretches only the emit phase. The next request is
// taken as soon as the last result of the current one sits in the output
// register. Lists live in one store of 2*LIST_DEPTH words, list one in the
// lower half. No clearing pass: entries are read only below a list's length.
// ----------------------------------------------------------------------------
module two_list_store_sort_reverse_concat_top #(
    parameter int LIST_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    tlsrc_in_if.sink    op,
    tlsrc_out_if.source result
);

    localparam int AW = $clog2(2*LIST_DEPTH);
    localparam int LW = $clog2(LIST_DEPTH+1);

    tlsrc_pkg::dp_cmd_t  dp_cmd;
    tlsrc_pkg::dp_stat_t dp_stat;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       wr_addr;
    logic [LW-1:0]       len1;
    logic [LW-1:0]       len2;

    // sequencer: decodes the request and walks the store
    tlsrc_ctrl #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (op.valid),
        .in_kind  (op.kind),
        .in_sel   (op.list_select),
        .in_ready (op.ready),
        .stat     (dp_stat),
        .len1     (len1),
        .len2     (len2),
        .cmd      (dp_cmd),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr)
    );

    // store, lengths and the result register
    tlsrc_datapath #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (dp_cmd),
        .rd_addr    (rd_addr),
        .wr_addr    (wr_addr),
        .in_value   (op.value),
        .out_ready  (result.ready),
        .out_valid  (result.valid),
        .out_value  (result.value_res),
        .out_last   (result.last),
        .out_status (result.status),
        .out_count  (result.count),
        .stat       (dp_stat),
        .len1       (len1),
        .len2       (len2)
    );

    // lengths never pass the list bound
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (len1 <= LW'(LIST_DEPTH)) && (len2 <= LW'(LIST_DEPTH)))
        else $error("list length beyond bound");

    // an accepted request closes the channel in the following cycle
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        op.valid && op.ready |=> !op.ready)
        else $error("request accepted while busy");

    // the store is never written while idle
    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.wr_en |-> !op.ready)
        else $error("store write while idle");

    // lengths only move while a request is worked
    a_len_stable_idle: assert property (@(posedge clk) disable iff (!rst_n)
        op.ready |=> $stable(len1) && $stable(len2))
        else $error("length changed out of an operation");

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-list store. A behavioral model of both
// lists predicts every result of each accepted request; results are checked
// in order, field by field. Directed tests cover empty lists, extreme values,
// sort, reverse, concat and ignored kinds. Random mixes then run under
// several source/sink idle patterns, and a capacity test fills both lists.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH    = 16;
    // Worst request: a 16-entry sort plus 16 results under a heavy sink stall,
    // with about 200 requests in all.
    localparam int CYCLE_LIMIT   = 600_000;
    localparam int SETTLE_CYCLES = 40;      // quiet time after the last result
    localparam int MAX_REPORTS   = 40;      // cap on printed mismatch lines

    // Kind codes that the block ignores (no result).
    localparam logic [2:0] KIND_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] KIND_UNUSED_LAST  = 3'd7;

    localparam logic signed [31:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VALUE_MAX = 32'sh7FFF_FFFF;

    typedef struct {
        logic signed [31:0] value_res;
        logic               last;
        logic [1:0]         status;
        logic [4:0]         count;
    } list_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    tlsrc_in_if  op_bus ();
    tlsrc_out_if result_bus ();

    two_list_store_sort_reverse_concat_top #(
        .LIST_DEPTH (LIST_DEPTH)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .op     (op_bus),
        .result (result_bus)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Model of the two lists. Index 0 is list one, index 1 is list two.
    // Entries at or above a list's length are never read.
    // ------------------------------------------------------------------------
    logic signed [31:0] list_mem [2][LIST_DEPTH];
    int                 list_len [2] = '{0, 0};
    list_result_t       pending_results [$];   // expected results, oldest first

    int errors         = 0;
    int cycle_count    = 0;
    int src_idle_pct   = 0;   // chance (%) that the source idles a cycle
    int sink_stall_pct = 0;   // chance (%) that the sink drops ready a cycle

    function automatic void push_result(logic signed [31:0] v, logic last,
                                        logic [1:0] st, int cnt);
        list_result_t r;
        r.value_res = v;
        r.last      = last;
        r.status    = st;
        r.count     = cnt[4:0];
        pending_results.push_back(r);
    endfunction

    // A list display: one result per element, last mark on the final one;
    // an empty list gives a single "empty" status result instead.
    function automatic void push_list_contents(int sel);
        int n;
        n = list_len[sel];
        if (n == 0)
            push_result('0, 1'b1, tlsrc_pkg::ST_EMPTY, 0);
        else
            for (int i = 0; i < n; i++)
                push_result(list_mem[sel][i], i == n - 1, tlsrc_pkg::ST_OK, n);
    endfunction

    function automatic void predict_request(logic [2:0] kind, logic sel,
                                            logic signed [31:0] value);
        int                 n;
        logic signed [31:0] t;
        n = list_len[sel];
        case (kind)
            tlsrc_pkg::KIND_APPEND:
                if (n >= LIST_DEPTH)
                    push_result('0, 1'b1, tlsrc_pkg::ST_FULL, n);
                else
                begin
                    list_mem[sel][n] = value;
                    list_len[sel]    = n + 1;
                    push_result('0, 1'b1, tlsrc_pkg::ST_OK, n + 1);
                end
            tlsrc_pkg::KIND_REVERSE:
            begin
                for (int i = 0; i < n / 2; i++)
                begin
                    t                        = list_mem[sel][i];
                    list_mem[sel][i]         = list_mem[sel][n - 1 - i];
                    list_mem[sel][n - 1 - i] = t;
                end
                push_list_contents(sel);
            end
            tlsrc_pkg::KIND_SORT:
            begin
                // exchange sort, signed ascending
                for (int i = 0; i < n; i++)
                    for (int j = i + 1; j < n; j++)
                        if (list_mem[sel][i] > list_mem[sel][j])
                        begin
                            t                = list_mem[sel][i];
                            list_mem[sel][i] = list_mem[sel][j];
                            list_mem[sel][j] = t;
                        end
                push_list_contents(sel);
            end
            tlsrc_pkg::KIND_CONCAT:
                // list_select plays no part; count always refers to list one
                if (list_len[0] + list_len[1] > LIST_DEPTH)
                    push_result('0, 1'b1, tlsrc_pkg::ST_FULL, list_len[0]);
                else
                begin
                    for (int i = 0; i < list_len[1]; i++)
                        list_mem[0][list_len[0] + i] = list_mem[1][i];
                    list_len[0] = list_len[0] + list_len[1];
                    push_list_contents(0);
                end
            tlsrc_pkg::KIND_DISPLAY:
                push_list_contents(sel);
            default:
                ;   // unused kinds: no result, no state change
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: at each rising edge, check an accepted result against the
    // oldest expectation, then predict the results of an accepted request.
    // A request's results can only show up on later edges, so the order of
    // the two steps within one edge does not matter.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        list_result_t want;
        if (rst_n)
        begin
            if (result_bus.valid && result_bus.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: unexpected result value_res=%0d last=%0b status=%0d count=%0d, expected none",
                                 $time, result_bus.value_res, result_bus.last,
                                 result_bus.status, result_bus.count);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (want.value_res !== result_bus.value_res ||
                        want.last      !== result_bus.last      ||
                        want.status    !== result_bus.status    ||
                        want.count     !== result_bus.count)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("%0t: mismatch expected value_res=%0d last=%0b status=%0d count=%0d, actual value_res=%0d last=%0b status=%0d count=%0d",
                                     $time, want.value_res, want.last, want.status,
                                     want.count, result_bus.value_res, result_bus.last,
                                     result_bus.status, result_bus.count);
                    end
                end
            end
            if (op_bus.valid && op_bus.ready)
                predict_request(op_bus.kind, op_bus.list_select, op_bus.value);
        end
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Sink back-pressure, changed only at the falling edge.
    always @(negedge clk)
        result_bus.ready = ($urandom_range(99) >= sink_stall_pct);

    // ------------------------------------------------------------------------
    // Request driver. Drives at the falling edge, optionally idling first
    // (with junk payload under valid low), then holds the request until the
    // rising edge that accepts it. Valid is left high on return so that back
    // to back requests never see a low-high glitch within one step; anything
    // that stops sending calls wait_for_drain, which lowers it.
    // ------------------------------------------------------------------------
    task automatic send_request(input logic [2:0] kind, input logic sel,
                                input logic signed [31:0] value);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            op_bus.valid       = 1'b0;
            op_bus.kind        = 3'($urandom);
            op_bus.list_select = 1'($urandom);
            op_bus.value       = $urandom;
            @(negedge clk);
        end
        op_bus.valid       = 1'b1;
        op_bus.kind        = kind;
        op_bus.list_select = sel;
        op_bus.value       = value;
        do
            @(posedge clk);
        while (!op_bus.ready);
    endtask

    // Stop sending and wait until every predicted result has been seen.
    task automatic wait_for_drain();
        @(negedge clk);
        op_bus.valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Extremes, small values (for duplicates in sorts) and full-range values.
    function automatic logic signed [31:0] random_value();
        case ($urandom_range(7))
            0:       return VALUE_MIN;
            1:       return VALUE_MAX;
            2, 3:    return $signed(32'($urandom_range(8))) - 32'sd4;
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Display, reverse, sort and concat on empty lists; concat of two empty lists.
    task automatic test_empty_lists();
        send_request(tlsrc_pkg::KIND_DISPLAY, 1'b0, random_value());
        send_request(tlsrc_pkg::KIND_REVERSE, 1'b1, random_value());
        send_request(tlsrc_pkg::KIND_SORT,    1'b0, random_value());
        send_request(tlsrc_pkg::KIND_SORT,    1'b1, random_value());
        send_request(tlsrc_pkg::KIND_CONCAT,  1'b0, random_value());
    endtask

    // Extreme values; reverse of a single entry; concat into an empty list one.
    task automatic test_append_extremes();
        send_request(tlsrc_pkg::KIND_APPEND,  1'b1, VALUE_MIN);
        send_request(tlsrc_pkg::KIND_REVERSE, 1'b1, random_value());
        send_request(tlsrc_pkg::KIND_CONCAT,  1'b0, random_value());
        send_request(tlsrc_pkg::KIND_APPEND,  1'b0, VALUE_MAX);
        send_request(tlsrc_pkg::KIND_APPEND,  1'b0, 32'sd0);
        send_request(tlsrc_pkg::KIND_APPEND,  1'b0, -32'sd1);
        send_request(tlsrc_pkg::KIND_APPEND,  1'b0, 32'sd1);
    endtask

    // Signed sort across the extremes, reverse of an odd length, duplicates.
    task automatic test_sort_reverse();
        send_request(tlsrc_pkg::KIND_SORT,    1'b0, random_value());
        send_request(tlsrc_pkg::KIND_REVERSE, 1'b0, random_value());
        send_request(tlsrc_pkg::KIND_APPEND,  1'b1, 32'sd5);
        send_request(tlsrc_pkg::KIND_APPEND,  1'b1, 32'sd5);
        send_request(tlsrc_pkg::KIND_SORT,    1'b1, random_value());
        send_request(tlsrc_pkg::KIND_DISPLAY, 1'b1, random_value());
    endtask

    // Concat of two non-empty lists, issued with list_select set.
    task automatic test_concat_select();
        send_request(tlsrc_pkg::KIND_CONCAT,  1'b1, random_value());
        send_request(tlsrc_pkg::KIND_DISPLAY, 1'b0, random_value());
    endtask

    // Unused kinds after a full drain; a display shows nothing changed.
    task automatic test_ignored_kinds();
        wait_for_drain();
        for (int k = KIND_UNUSED_FIRST; k <= KIND_UNUSED_LAST; k++)
            send_request(3'(k), 1'($urandom), random_value());
        send_request(tlsrc_pkg::KIND_DISPLAY, 1'b1, random_value());
    endtask

    // Random mix of requests; appends are kept rare so lists grow across the
    // whole run. Ignored kinds are sent but not counted.
    task automatic test_random_mix(input int items);
        int         sent;
        int         pick;
        logic [2:0] kind;
        sent = 0;
        while (sent < items)
        begin
            pick = $urandom_range(99);
            if (pick < 20)
                kind = tlsrc_pkg::KIND_APPEND;
            else if (pick < 36)
                kind = tlsrc_pkg::KIND_REVERSE;
            else if (pick < 54)
                kind = tlsrc_pkg::KIND_SORT;
            else if (pick < 66)
                kind = tlsrc_pkg::KIND_CONCAT;
            else if (pick < 93)
                kind = tlsrc_pkg::KIND_DISPLAY;
            else
                kind = 3'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST));
            send_request(kind, 1'($urandom), random_value());
            if (kind < KIND_UNUSED_FIRST)
                sent++;
        end
    endtask

    // Fill both lists, append once more to each (full), refused concat, and
    // full-length sort, reverse and display.
    task automatic test_capacity();
        int missing;
        wait_for_drain();   // model lengths are stable only once drained
        for (int sel = 0; sel < 2; sel++)
        begin
            missing = LIST_DEPTH - list_len[sel];
            for (int i = 0; i <= missing; i++)
                send_request(tlsrc_pkg::KIND_APPEND, sel[0], random_value());
        end
        send_request(tlsrc_pkg::KIND_CONCAT,  1'b0, random_value());
        send_request(tlsrc_pkg::KIND_SORT,    1'b1, random_value());
        send_request(tlsrc_pkg::KIND_REVERSE, 1'b0, random_value());
        send_request(tlsrc_pkg::KIND_DISPLAY, 1'b1, random_value());
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        op_bus.valid       = 1'b0;
        op_bus.kind        = tlsrc_pkg::KIND_APPEND;
        op_bus.list_select = 1'b0;
        op_bus.value       = '0;
        result_bus.ready   = 1'b0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part, no idling on either side
        test_empty_lists();
        test_append_extremes();
        test_sort_reverse();
        test_concat_select();
        test_ignored_kinds();

        // random part under each idle pattern; drain between phases
        wait_for_drain();
        test_random_mix(30);

        wait_for_drain();
        src_idle_pct = 66;
        test_random_mix(30);

        wait_for_drain();
        src_idle_pct   = 0;
        sink_stall_pct = 66;
        test_random_mix(30);

        wait_for_drain();
        src_idle_pct   = 37;
        sink_stall_pct = 37;
        test_random_mix(30);

        test_capacity();

        // all requests in; wait for the tail, then watch for stray results
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (errors == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== two_list_store_sort_reverse_concat_top.f =====
rtl/core/tlsrc_pkg.sv
rtl/core/tlsrc_in_if.sv
rtl/core/tlsrc_out_if.sv
rtl/core/tlsrc_datapath.sv
rtl/core/tlsrc_ctrl.sv
rtl/core/two_list_store_sort_reverse_concat_top.sv
tb/testbench.sv
